// ----- rtl/mcrms_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcrms_pkg : shared constants for the multichannel rms meter
// Field widths, register map, operation codes and sequencer step counts.
// ----------------------------------------------------------------------------
package mcrms_pkg;

    // channel count and index width
    localparam int CHANNELS = 8;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // item field widths
    localparam int SAMPLE_W = 8;
    localparam int MAG_W    = 7;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int SUM_W    = 22;
    localparam int CNT_W    = 8;
    localparam int TICK_W   = 16;
    localparam int REARM_W  = 7;
    localparam int FSEL_W   = 3;
    localparam int OCH_W    = 3;
    localparam int RMS_W    = 7;
    localparam int CMP_W    = (CH_W > FSEL_W) ? CH_W : FSEL_W;

    // stream payload widths
    localparam int S_DATA_W    = 8;
    localparam int M_PAYLOAD_W = OCH_W + RMS_W + TICK_W;
    localparam int M_DATA_W    = ((M_PAYLOAD_W + 7) / 8) * 8;

    // operation codes carried on the input tuser
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // limits
    localparam logic [CNT_W-1:0]  CNT_MAX   = '1;
    localparam logic [TICK_W-1:0] TICKS_MAX = '1;

    // configuration reset values
    localparam logic [REARM_W-1:0] REARM_RESET     = 7'd120;
    localparam logic [FSEL_W-1:0]  FSEL_RESET      = 3'd6;
    localparam logic [TICK_W-1:0]  TICK_RATE_RESET = 16'd62500;

    // shared subtractor and sequencer
    localparam int ROOT_W     = 16;
    localparam int BIT_W      = 15;
    localparam logic [BIT_W-1:0] SQRT_TOP = 15'h4000;
    localparam int SUB_W      = TICK_W + 1;
    localparam int DIV_STEPS  = SUM_W;
    localparam int FREQ_STEPS = TICK_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    // apb register map
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_REARM = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_FSEL  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_TICK  = 2'd2;

endpackage

// ----- rtl/multichannel_rms_meter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_rms_meter : true rms and frequency meter over 8 channels
// Sample items arrive round-robin over the channels, tick items count time.
// A non-empty, unsaturated period closed by a rising crossing gives its rms
// and, on the frequency channel, tick_rate divided by the ticks of the period.
// ----------------------------------------------------------------------------
// A tick item is taken in the idle state, which the sequencer keeps. A sample
// item that gives no result goes through the exec state back to idle. One
// that gives a result runs a restoring divide of the square sum by the sample
// count, an 8-step square root and a rounding step, all on one shared 17-bit
// subtractor, and on the frequency channel, if the period is nonzero, the
// 16-step frequency divide on it too, ahead of the output register load.
// s_tready is low while the sequencer runs, and it also stays low while a
// new result waits for the output register to be taken downstream. A
// finished result sits in the output register and does not hold up the next
// item until a second result needs it.
// Registers (APB, byte address 4*i): 0 rearm_level, 1 freq_channel,
// 2 tick_rate.
module multichannel_rms_meter (
    input  logic                                clk,
    input  logic                                rst_n,
    // input item
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mcrms_pkg::S_DATA_W-1:0]      s_tdata,   // [7:0] sample
    input  logic                                s_tuser,   // [0] op
    // result item
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mcrms_pkg::M_DATA_W-1:0]      m_tdata,   // [2:0] channel, [9:3] rms,
                                                           // [25:10] frequency
    output logic                                m_tuser,   // [0] freq_valid
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mcrms_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [mcrms_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [mcrms_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);
    import mcrms_pkg::*;

    // sequencer state codes
    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_IDLE  = 3'd0;
    localparam logic [ST_W-1:0] ST_EXEC  = 3'd1;
    localparam logic [ST_W-1:0] ST_DIV   = 3'd2;
    localparam logic [ST_W-1:0] ST_SQRT  = 3'd3;
    localparam logic [ST_W-1:0] ST_ROUND = 3'd4;
    localparam logic [ST_W-1:0] ST_FREQ  = 3'd5;
    localparam logic [ST_W-1:0] ST_OUT   = 3'd6;

    logic [ST_W-1:0]     state_reg;
    logic [ST_W-1:0]     state_next;

    // configuration registers
    logic [REARM_W-1:0]  rearm_reg;
    logic [FSEL_W-1:0]   fsel_reg;
    logic [TICK_W-1:0]   tick_rate_reg;

    // per-channel state
    logic                armed_reg [CHANNELS];
    logic [SUM_W-1:0]    sum_reg   [CHANNELS];
    logic [CNT_W-1:0]    count_reg [CHANNELS];
    logic [CH_W-1:0]     cur_ch_reg;
    logic [TICK_W-1:0]   period_reg;

    // working registers of the sequencer
    logic [SAMPLE_W-1:0] s_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [TICK_W-1:0]   period_hold_reg;
    logic                is_freq_reg;
    logic [OCH_W-1:0]    ch_out_reg;
    logic [SUM_W-1:0]    quo_reg;
    logic [ROOT_W-1:0]   rem_reg;
    logic [BIT_W-1:0]    bit_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [RMS_W-1:0]    rms_reg;

    // output register
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic                m_tuser_reg;

    // sample decode
    logic [MAG_W-1:0]    mag;
    logic [SQ_W-1:0]     sq;
    logic [CNT_W-1:0]    cnt_old;
    logic [SUM_W-1:0]    sum_old;
    logic [CNT_W-1:0]    base_cnt;
    logic [SUM_W-1:0]    base_sum;
    logic                rise;
    logic                is_freq;
    logic                emit;
    logic                rearm_hit;

    // shared subtractor
    logic [SUB_W-1:0]    sub_a;
    logic [SUB_W-1:0]    sub_b;
    logic [SUB_W-1:0]    sub_diff;
    logic                sub_borrow;
    logic                sub_ge;
    logic [ROOT_W-1:0]   root_sh;
    logic [SUM_W-1:0]    div_quo;

    logic                cfg_wr;
    logic                out_free;
    logic                in_take;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign s_tready = (state_reg == ST_IDLE);
    assign in_take  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // register read back
    always_comb
    begin
        unique case (paddr[APB_ADDR_W-1:2])
            REG_REARM: prdata = APB_DATA_W'(rearm_reg);
            REG_FSEL:  prdata = APB_DATA_W'(fsel_reg);
            REG_TICK:  prdata = APB_DATA_W'(tick_rate_reg);
            default:   prdata = '0;
        endcase
    end

    // magnitude about the midpoint, square and crossing detection
    always_comb
    begin
        mag       = s_reg[SAMPLE_W-1] ? s_reg[MAG_W-1:0] : ~s_reg[MAG_W-1:0];
        sq        = SQ_W'(mag) * SQ_W'(mag);
        cnt_old   = count_reg[cur_ch_reg];
        sum_old   = sum_reg[cur_ch_reg];
        rise      = s_reg[SAMPLE_W-1] && !armed_reg[cur_ch_reg];
        rearm_hit = !s_reg[SAMPLE_W-1] && (s_reg[MAG_W-1:0] < rearm_reg);
        base_cnt  = rise ? '0 : cnt_old;
        base_sum  = rise ? '0 : sum_old;
        is_freq   = (CMP_W'(cur_ch_reg) == CMP_W'(fsel_reg));
        emit      = rise && (cnt_old != '0) && (cnt_old != CNT_MAX);
    end

    // operand selection for the shared subtractor
    always_comb
    begin
        sub_a = '0;
        sub_b = '0;
        unique case (state_reg)
            ST_DIV:
            begin
                sub_a = SUB_W'({rem_reg[CNT_W-1:0], quo_reg[SUM_W-1]});
                sub_b = SUB_W'(cnt_reg);
            end
            ST_SQRT:
            begin
                sub_a = SUB_W'(rem_reg);
                sub_b = SUB_W'(quo_reg[ROOT_W-1:0] | ROOT_W'(bit_reg));
            end
            ST_ROUND:
            begin
                sub_a = SUB_W'(quo_reg[ROOT_W-1:0]);
                sub_b = SUB_W'(rem_reg);
            end
            ST_FREQ:
            begin
                sub_a = {rem_reg, quo_reg[TICK_W-1]};
                sub_b = SUB_W'(period_hold_reg);
            end
            default:
            begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
        {sub_borrow, sub_diff} = {1'b0, sub_a} - {1'b0, sub_b};
        sub_ge  = !sub_borrow;
        root_sh = quo_reg[ROOT_W-1:0] >> 1;
        div_quo = {quo_reg[SUM_W-2:0], sub_ge};
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_take && (s_tuser == OP_SAMPLE))
                    state_next = ST_EXEC;
            ST_EXEC:
                state_next = emit ? ST_DIV : ST_IDLE;
            ST_DIV:
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                    state_next = ST_SQRT;
            ST_SQRT:
                if (bit_reg[0])
                    state_next = ST_ROUND;
            ST_ROUND:
                state_next = (is_freq_reg && (period_hold_reg != '0)) ? ST_FREQ : ST_OUT;
            ST_FREQ:
                if (step_reg == STEP_W'(FREQ_STEPS - 1))
                    state_next = ST_OUT;
            ST_OUT:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath, channel state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            rearm_reg       <= REARM_RESET;
            fsel_reg        <= FSEL_RESET;
            tick_rate_reg   <= TICK_RATE_RESET;
            for (int i = 0; i < CHANNELS; i++)
            begin
                armed_reg[i] <= 1'b0;
                sum_reg[i]   <= '0;
                count_reg[i] <= '0;
            end
            cur_ch_reg      <= '0;
            period_reg      <= '0;
            s_reg           <= '0;
            cnt_reg         <= '0;
            period_hold_reg <= '0;
            is_freq_reg     <= 1'b0;
            ch_out_reg      <= '0;
            quo_reg         <= '0;
            rem_reg         <= '0;
            bit_reg         <= '0;
            step_reg        <= '0;
            rms_reg         <= '0;
            m_tvalid_reg    <= 1'b0;
            m_tdata_reg     <= '0;
            m_tuser_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // configuration writes
            if (cfg_wr)
            begin
                unique case (paddr[APB_ADDR_W-1:2])
                    REG_REARM: rearm_reg     <= pwdata[REARM_W-1:0];
                    REG_FSEL:  fsel_reg      <= pwdata[FSEL_W-1:0];
                    REG_TICK:  tick_rate_reg <= pwdata[TICK_W-1:0];
                    default:   ;
                endcase
            end

            // new result item loaded, or the waiting one taken downstream
            if ((state_reg == ST_OUT) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= M_DATA_W'({quo_reg[TICK_W-1:0], rms_reg, ch_out_reg});
                m_tuser_reg  <= is_freq_reg;
            end
            else if (m_tvalid_reg && m_tready)
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_take)
                    begin
                        if (s_tuser == OP_TICK)
                        begin
                            if (period_reg != TICKS_MAX)
                                period_reg <= period_reg + TICK_W'(1);
                        end
                        else
                            s_reg <= s_tdata;
                    end
                end
                ST_EXEC:
                begin
                    // accumulate the square unless the count has saturated
                    if (base_cnt != CNT_MAX)
                    begin
                        sum_reg[cur_ch_reg]   <= base_sum + SUM_W'(sq);
                        count_reg[cur_ch_reg] <= base_cnt + CNT_W'(1);
                    end
                    if (rise)
                        armed_reg[cur_ch_reg] <= 1'b1;
                    else if (rearm_hit)
                        armed_reg[cur_ch_reg] <= 1'b0;
                    if (rise && is_freq)
                    begin
                        period_hold_reg <= period_reg;
                        period_reg      <= '0;
                    end
                    // round-robin channel advance
                    if (cur_ch_reg == CH_W'(CHANNELS - 1))
                        cur_ch_reg <= '0;
                    else
                        cur_ch_reg <= cur_ch_reg + CH_W'(1);
                    // set up the mean divide
                    cnt_reg     <= cnt_old;
                    is_freq_reg <= is_freq;
                    ch_out_reg  <= OCH_W'(cur_ch_reg);
                    quo_reg     <= sum_old;
                    rem_reg     <= '0;
                    step_reg    <= '0;
                end
                ST_DIV:
                begin
                    // one quotient bit per cycle
                    if (step_reg == STEP_W'(DIV_STEPS - 1))
                    begin
                        rem_reg  <= div_quo[ROOT_W-1:0];
                        quo_reg  <= '0;
                        bit_reg  <= SQRT_TOP;
                        step_reg <= '0;
                    end
                    else
                    begin
                        rem_reg  <= sub_ge ? sub_diff[ROOT_W-1:0] : sub_a[ROOT_W-1:0];
                        quo_reg  <= div_quo;
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                ST_SQRT:
                begin
                    // one root bit per cycle, root kept in quo_reg
                    if (sub_ge)
                    begin
                        quo_reg <= SUM_W'(root_sh | ROOT_W'(bit_reg));
                        rem_reg <= sub_diff[ROOT_W-1:0];
                    end
                    else
                        quo_reg <= SUM_W'(root_sh);
                    bit_reg <= bit_reg >> 2;
                end
                ST_ROUND:
                begin
                    // round up when the remainder exceeds the root
                    rms_reg  <= quo_reg[RMS_W-1:0] + RMS_W'(sub_borrow);
                    rem_reg  <= '0;
                    step_reg <= '0;
                    if (is_freq_reg && (period_hold_reg != '0))
                        quo_reg <= SUM_W'(tick_rate_reg);
                    else
                        quo_reg <= '0;
                end
                ST_FREQ:
                begin
                    rem_reg  <= sub_ge ? sub_diff[ROOT_W-1:0] : sub_a[ROOT_W-1:0];
                    quo_reg  <= SUM_W'({quo_reg[TICK_W-2:0], sub_ge});
                    step_reg <= step_reg + STEP_W'(1);
                end
                default: ;
            endcase
        end
    end

endmodule

// ----- tb/rms_meter_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_meter_checker : prediction and comparison for the rms meter
// Watches the register port and both item streams, keeps its own copy of
// the meter state, predicts each reading and checks it field by field.
// ----------------------------------------------------------------------------
module rms_meter_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [mcrms_pkg::S_DATA_W-1:0]      s_tdata,   // [7:0] sample
    input  logic                                s_tuser,   // [0] op
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [mcrms_pkg::M_DATA_W-1:0]      m_tdata,   // [2:0] channel, [9:3] rms,
                                                           // [25:10] frequency
    input  logic                                m_tuser,   // [0] freq_valid
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic                                pready,
    input  logic [mcrms_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [mcrms_pkg::APB_DATA_W-1:0]    pwdata,
    output int                                  failures,
    output int                                  waiting,
    output int                                  checked
);
    import mcrms_pkg::*;

    typedef struct packed {
        logic [OCH_W-1:0]  channel;
        logic [RMS_W-1:0]  rms;
        logic              freq_valid;
        logic [TICK_W-1:0] frequency;
    } reading_t;

    // register copies
    logic [REARM_W-1:0] rearm;
    logic [FSEL_W-1:0]  freq_sel;
    logic [TICK_W-1:0]  rate;

    // meter state
    logic [CH_W-1:0]     chan_ptr;
    logic [CHANNELS-1:0] latched;
    logic [SUM_W-1:0]    sqsum [CHANNELS];
    logic [CNT_W-1:0]    count [CHANNELS];
    logic [TICK_W-1:0]   tick_run;

    reading_t pending_readings [$];

    // rounded integer root: remainder above the root rounds up
    function automatic logic [RMS_W-1:0] rounded_root(input logic [15:0] v);
        int r;
        r = 0;
        while ((r + 1) * (r + 1) <= int'(v))
            r++;
        if (int'(v) - r * r > r)
            r++;
        return r[RMS_W-1:0];
    endfunction

    task automatic count_tick();
        if (tick_run != TICKS_MAX)
            tick_run = tick_run + 1'b1;
    endtask

    // one sample on the current channel, queuing a reading on a rising edge
    task automatic take_sample(input logic [7:0] smp);
        logic [CH_W-1:0]   ch;
        logic [MAG_W-1:0]  mag;
        logic [SQ_W-1:0]   sq;
        logic [15:0]       mean;
        logic [TICK_W-1:0] hz;
        logic              on_freq;
        reading_t          rd;
        ch = chan_ptr;
        if (smp[7]) begin
            if (!latched[ch]) begin
                on_freq = (ch == freq_sel);
                hz = '0;
                if (on_freq) begin
                    if (tick_run != 0)
                        hz = rate / tick_run;
                    tick_run = '0;
                end
                // empty and saturated periods give nothing
                if (count[ch] != 0 && count[ch] != CNT_MAX) begin
                    mean = 16'(sqsum[ch] / count[ch]);
                    rd.channel    = ch;
                    rd.rms        = rounded_root(mean);
                    rd.freq_valid = on_freq;
                    rd.frequency  = on_freq ? hz : '0;
                    pending_readings.push_back(rd);
                end
                sqsum[ch] = '0;
                count[ch] = '0;
                latched[ch] = 1'b1;
            end
            mag = smp[6:0];
        end else begin
            if (smp < rearm)
                latched[ch] = 1'b0;
            mag = 7'd127 - smp[6:0];
        end
        // edge sample opens the new period
        if (count[ch] != CNT_MAX) begin
            sq = mag * mag;
            sqsum[ch] = sqsum[ch] + sq;
            count[ch] = count[ch] + 1'b1;
        end
        chan_ptr = (ch == CHANNELS - 1) ? '0 : ch + 1'b1;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        reading_t want;
        if (!rst_n) begin
            rearm    = REARM_RESET;
            freq_sel = FSEL_RESET;
            rate     = TICK_RATE_RESET;
            chan_ptr = '0;
            latched  = '0;
            sqsum    = '{default: '0};
            count    = '{default: '0};
            tick_run = '0;
            pending_readings.delete();
            failures = 0;
            waiting  = 0;
            checked  = 0;
        end else begin
            // register writes
            if (psel && penable && pwrite && pready) begin
                case (paddr[APB_ADDR_W-1:2])
                    REG_REARM: rearm    = pwdata[REARM_W-1:0];
                    REG_FSEL:  freq_sel = pwdata[FSEL_W-1:0];
                    REG_TICK:  rate     = pwdata[TICK_W-1:0];
                    default: ;
                endcase
            end
            // accepted input item
            if (s_tvalid && s_tready) begin
                if (s_tuser == OP_TICK)
                    count_tick();
                else
                    take_sample(s_tdata);
            end
            // accepted reading
            if (m_tvalid && m_tready) begin
                if (pending_readings.size() == 0) begin
                    $error("reading for channel %0d with nothing expected",
                           m_tdata[OCH_W-1:0]);
                    failures++;
                end else begin
                    want = pending_readings.pop_front();
                    check_field("channel", int'(want.channel), int'(m_tdata[OCH_W-1:0]));
                    check_field("rms", int'(want.rms), int'(m_tdata[OCH_W +: RMS_W]));
                    check_field("freq_valid", int'(want.freq_valid), int'(m_tuser));
                    check_field("frequency", int'(want.frequency),
                                int'(m_tdata[OCH_W+RMS_W +: TICK_W]));
                    checked++;
                end
            end
            waiting = pending_readings.size();
        end
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench : top level for the multichannel rms meter
// Drives sample and tick items in bursts through several register settings,
// stalls the reading stream, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;
    import mcrms_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 500;

    typedef enum {SINK_OPEN, SINK_HALF, SINK_SPARSE, SINK_MOSTLY} sink_mode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;    // [7:0] sample
    logic                  s_tuser;    // [0] op
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;    // [2:0] channel, [9:3] rms, [25:10] frequency
    logic                  m_tuser;    // [0] freq_valid
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int failures;
    int waiting;
    int checked;
    int cycle_count;

    // stimulus bookkeeping
    int items_sent;
    int ticks_sent;
    int regs_written;
    int burst_left;
    int next_ch;
    int rearm_now;
    int half_len [CHANNELS];
    int wave_pos [CHANNELS];

    // opening rounds: extremes, empty periods, hysteresis and a zero period
    logic [7:0] opening [0:23] = '{
        8'd255, 8'd0,   8'd128, 8'd127, 8'd119, 8'd120, 8'd200, 8'd1,
        8'd0,   8'd255, 8'd100, 8'd128, 8'd255, 8'd255, 8'd50,  8'd130,
        8'd128, 8'd144, 8'd160, 8'd176, 8'd192, 8'd208, 8'd224, 8'd240
    };

    multichannel_rms_meter dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    rms_meter_checker rms_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .pready   (pready),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .failures (failures),
        .waiting  (waiting),
        .checked  (checked)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d readings outstanding", cycle_count, waiting);
        $display("FAILED: results differ");
        $finish;
    end

    // reading sink: changing stall patterns plus two long hold-offs
    initial
    begin : reading_sink
        sink_mode_t mode;
        int mode_left;
        int hold_left;
        int taken;
        int holds_done;
        mode = SINK_OPEN;
        mode_left = 0;
        hold_left = 0;
        taken = 0;
        holds_done = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                taken++;
            if (hold_left == 0 && ((holds_done == 0 && taken >= 15) ||
                                   (holds_done == 1 && taken >= 60)))
            begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = sink_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(8, 150);
                end
                mode_left--;
                case (mode)
                    SINK_OPEN:   m_tready <= 1'b1;
                    SINK_HALF:   m_tready <= 1'($urandom_range(0, 1));
                    SINK_SPARSE: m_tready <= ($urandom_range(0, 4) == 0);
                    default:     m_tready <= ($urandom_range(0, 19) != 0);
                endcase
            end
        end
    end

    // one item, then the burst and gap pattern of the sender
    task automatic send(input logic op, input logic [7:0] smp);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= smp;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        if (op == OP_TICK)
            ticks_sent++;
        else
            next_ch = (next_ch == CHANNELS - 1) ? 0 : next_ch + 1;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // hold the sender until every predicted reading has come back
    task automatic wait_readings();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
    endtask

    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        regs_written++;
    endtask

    // new settings, written only once the meter has gone quiet
    task automatic configure(input int level, input int fch, input int rate);
        wait_readings();
        repeat (SETTLE_CYCLES) @(posedge clk);
        apb_write(REG_REARM, level);
        apb_write(REG_FSEL, fch);
        apb_write(REG_TICK, rate);
        rearm_now = level;
    endtask

    // low sample, mostly below the re-arm level, sometimes in the hysteresis band
    function automatic logic [7:0] low_level();
        if (rearm_now == 0 || $urandom_range(0, 5) == 0)
            return 8'($urandom_range(0, 127));
        return 8'($urandom_range(0, rearm_now - 1));
    endfunction

    // square-ish waves per channel with random periods, ticks and noise
    task automatic random_items(input int n);
        int i;
        int c;
        logic [7:0] smp;
        for (i = 0; i < n; i++)
        begin
            if (i == n / 2)
                wait_readings();
            if ($urandom_range(0, 4) == 0)
                send(OP_TICK, 8'($urandom()));
            else
            begin
                c = next_ch;
                if ($urandom_range(0, 11) == 0)
                    smp = 8'($urandom());
                else if (wave_pos[c] < half_len[c])
                    smp = 8'($urandom_range(128, 255));
                else
                    smp = low_level();
                wave_pos[c]++;
                if (wave_pos[c] >= 2 * half_len[c])
                begin
                    wave_pos[c] = 0;
                    half_len[c] = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30)
                                                              : $urandom_range(1, 5);
                end
                send(OP_SAMPLE, smp);
            end
        end
    endtask

    initial
    begin : stimulus
        int i;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_SAMPLE;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        items_sent = 0;
        ticks_sent = 0;
        regs_written = 0;
        burst_left = 0;
        next_ch = 0;
        rearm_now = REARM_RESET;
        half_len = '{default: 0};
        wave_pos = '{default: 0};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // opening rounds at reset settings, then two ticks
        for (i = 0; i < 24; i++)
            send(OP_SAMPLE, opening[i]);
        send(OP_TICK, 8'hff);
        send(OP_TICK, 8'h00);
        random_items(140);

        // extreme settings and a few in between
        configure(127, 0, 16'hffff);
        random_items(130);
        configure(0, 7, 1);
        random_items(40);
        configure(64, 3, 1);
        random_items(130);
        configure($urandom_range(0, 127), $urandom_range(0, 7), 0);
        random_items(60);

        wait_readings();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("run covered %0d items (%0d ticks) and %0d register writes",
                 items_sent, ticks_sent, regs_written);
        $display("%0d readings checked over five settings, incl. a zero tick rate and long stalls",
                 checked);
        if (failures == 0 && waiting == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
